@@ hw/rtl/ptd_pkg.sv @@
package ptd_pkg;

  localparam int unsigned SlotW  = 8;
  localparam int unsigned ColorW = 32;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned AddrW  = 3;

  // configuration register indexes
  localparam logic [AddrW-1:0] RegPaletteFormat = 3'd0;
  localparam logic [AddrW-1:0] RegIndexMode     = 3'd1;
  localparam logic [AddrW-1:0] RegIndexStart    = 3'd2;
  localparam logic [AddrW-1:0] RegIndexShift    = 3'd3;
  localparam logic [AddrW-1:0] RegIndexMask     = 3'd4;

  // palette entry formats
  localparam logic [1:0] FmtBgr5650  = 2'd0;
  localparam logic [1:0] FmtAbgr5551 = 2'd1;
  localparam logic [1:0] FmtAbgr4444 = 2'd2;
  localparam logic [1:0] FmtAbgr8888 = 2'd3;

  // index widths
  localparam logic [1:0] Mode4  = 2'd0;
  localparam logic [1:0] Mode8  = 2'd1;
  localparam logic [1:0] Mode16 = 2'd2;
  localparam logic [1:0] Mode32 = 2'd3;

  // input item commands
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdDecode = 1'b1;

  function automatic logic [ColorW-1:0] expand_entry(input logic [1:0] fmt,
                                                     input logic [ColorW-1:0] raw);
    logic [ColorW-1:0] res;
    unique case (fmt)
      FmtBgr5650: begin
        res = {8'hFF, raw[15:11], 3'b000, raw[10:5], 2'b00, raw[4:0], 3'b000};
      end
      FmtAbgr5551: begin
        res = {{8{raw[15]}}, raw[14:10], 3'b000, raw[9:5], 3'b000, raw[4:0], 3'b000};
      end
      FmtAbgr4444: begin
        res = {raw[15:12], 4'h0, raw[11:8], 4'h0, raw[7:4], 4'h0, raw[3:0], 4'h0};
      end
      default: begin
        res = raw;
      end
    endcase
    return res;
  endfunction

endpackage

@@ hw/rtl/palette_texel_decoder.sv @@
// Palette texel decoder. A load item (tuser 0) writes one raw entry into the
// palette memory. A decode item (tuser 1) is split into 8, 4, 2 or 1 indices
// by index_mode, and one 8888 color leaves per cycle while the output is not
// stalled, tlast marking the final texel of the word; the single read port of
// the palette memory sets that rate, and the next item is taken in the cycle
// the last lookup of the current word issues. The first texel passes the word
// register, the palette read register and the output register before it leaves.
// Reading a palette entry that was never loaded returns undefined data.
// Configuration must be written only while the block is idle; the block itself does not enforce this.
module palette_texel_decoder import ptd_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [AddrW-1:0]  cfg_addr_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // entry_slot[7:0], entry_value[39:8], texel_word[71:40]
  input  logic [71:0]       s_axis_tdata,
  // command[0]
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // texel_color[31:0]
  output logic [ColorW-1:0] m_axis_tdata,
  output logic              m_axis_tlast
);

  localparam int unsigned PalAw = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // remainder by restoring subtraction, correct only while the quotient fits in four bits
  function automatic logic [PalAw-1:0] wrap_slot(input logic [SlotW-1:0] v);
    logic [15:0] t;
    t = 16'(v);
    for (int i = 3; i >= 0; i--) begin
      if (t >= 16'(PALETTE_ENTRIES << i)) t = t - 16'(PALETTE_ENTRIES << i);
    end
    return t[PalAw-1:0];
  endfunction

  // configuration registers
  logic [1:0] palette_format_q;
  logic [1:0] index_mode_q;
  logic [8:0] index_start_q;
  logic [4:0] index_shift_q;
  logic [7:0] index_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_format_q <= FmtAbgr8888;
      index_mode_q     <= Mode8;
      index_start_q    <= '0;
      index_shift_q    <= '0;
      index_mask_q     <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegPaletteFormat: palette_format_q <= cfg_data_i[1:0];
        RegIndexMode:     index_mode_q     <= cfg_data_i[1:0];
        RegIndexStart:    index_start_q    <= cfg_data_i[8:0];
        RegIndexShift:    index_shift_q    <= cfg_data_i[4:0];
        RegIndexMask:     index_mask_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [SlotW-1:0]  in_slot;
  logic [ColorW-1:0] in_value;
  logic [31:0]       in_word;
  assign in_slot  = s_axis_tdata[7:0];
  assign in_value = s_axis_tdata[39:8];
  assign in_word  = s_axis_tdata[71:40];

  // issue stage: one palette lookup per cycle while the read stage is not stalled
  logic        busy_q, busy_d;
  logic [2:0]  k_q, k_d;
  logic [2:0]  kmax_q;
  logic [31:0] word_q;
  logic        issue, issue_last;

  // read stage and output register
  logic              rd_valid_q, rd_valid_d;
  logic              rd_last_q;
  logic [ColorW-1:0] rd_q;
  logic              rd_adv;
  logic              out_valid_q, out_valid_d;
  logic              out_last_q;
  logic [ColorW-1:0] out_color_q;

  logic s_fire, load_fire, dec_fire;

  assign rd_adv     = !out_valid_q || m_axis_tready;
  assign issue      = busy_q && (!rd_valid_q || rd_adv);
  assign issue_last = issue && (k_q == kmax_q);

  // a new item, load or decode, waits until all lookups of the previous word have issued
  assign s_axis_tready = !busy_q || issue_last;
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign load_fire = s_fire && (s_axis_tuser == CmdLoad);
  assign dec_fire  = s_fire && (s_axis_tuser == CmdDecode);

  // lookup address of the current index
  logic [31:0]      idx;
  logic [31:0]      sum;
  logic [31:0]      shifted;
  logic [7:0]       sel;
  logic [PalAw-1:0] rd_addr;

  always_comb begin
    unique case (index_mode_q)
      Mode4:   idx = {28'd0, word_q[3:0]};
      Mode8:   idx = {24'd0, word_q[7:0]};
      Mode16:  idx = {16'd0, word_q[15:0]};
      default: idx = word_q;
    endcase
    sum     = 32'(index_start_q) + idx;
    shifted = sum >> index_shift_q;
    sel     = shifted[7:0] & index_mask_q;
    rd_addr = wrap_slot(sel);
  end

  logic [2:0] in_kmax;
  always_comb begin
    unique case (index_mode_q)
      Mode4:   in_kmax = 3'd7;
      Mode8:   in_kmax = 3'd3;
      Mode16:  in_kmax = 3'd1;
      default: in_kmax = 3'd0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (issue) begin
      k_d = k_q + 3'd1;
      if (issue_last) busy_d = 1'b0;
    end
    if (dec_fire) begin
      busy_d = 1'b1;
      k_d    = '0;
    end
  end

  always_comb begin
    rd_valid_d = rd_valid_q;
    if (rd_adv) rd_valid_d = 1'b0;
    if (issue) rd_valid_d = 1'b1;
    out_valid_d = rd_adv ? rd_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      k_q         <= k_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (dec_fire) begin
      word_q <= in_word;
      kmax_q <= in_kmax;
    end else if (issue) begin
      unique case (index_mode_q)
        Mode4:   word_q <= word_q >> 4;
        Mode8:   word_q <= word_q >> 8;
        default: word_q <= word_q >> 16;
      endcase
    end
    if (issue) rd_last_q <= issue_last;
    if (rd_adv && rd_valid_q) begin
      out_color_q <= expand_entry(palette_format_q, rd_q);
      out_last_q  <= rd_last_q;
    end
  end

  // palette memory, read before write on the same entry
  logic [ColorW-1:0] palette_mem [PALETTE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (load_fire) palette_mem[wrap_slot(in_slot)] <= in_value;
    if (issue) rd_q <= palette_mem[rd_addr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_color_q;
  assign m_axis_tlast  = out_last_q;

  // a load never lands while lookups of an earlier word are still pending
  a_load_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |-> (!busy_q || issue_last))
    else $error("load accepted with pending lookups");

  // a lookup never overwrites read data that has not moved on
  a_no_rd_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (!rd_valid_q || rd_adv))
    else $error("read stage overrun");

  // a stalled read stage keeps its item
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && !rd_adv) |=> (rd_valid_q && $stable(rd_q) && $stable(rd_last_q)))
    else $error("read stage lost an item");

  // the word ends with a last texel before the block goes idle
  a_last_on_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !busy_d && !dec_fire) |-> issue_last)
    else $error("word finished without last lookup");

endmodule
